[hw/rtl/fpsa_pkg.sv]
package fpsa_pkg;

   localparam int OFS_BITS         = 21;
   localparam int HDR_BITS         = 7;
   localparam int FUNC_BITS        = 2;
   localparam int STATUS_BITS      = 3;
   localparam int FRAG_BITS        = 6;
   localparam int REG_IDX_BITS     = 2;
   localparam int CSR_DATA_BITS    = 21;
   localparam int DEF_MAX_SEGMENTS = 32;

   localparam logic [OFS_BITS-1:0] HEAP_SIZE_RST = 21'd65536;
   localparam logic [HDR_BITS-1:0] HEADER_RST    = 7'd24;

   localparam logic [FUNC_BITS-1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_FREE   = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_COUNT  = 2'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOFIT    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_BADSIZE  = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd4;

   localparam logic [REG_IDX_BITS-1:0] REG_HEAP_SIZE = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_HEADER    = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_POLICY    = 2'd2;

   typedef struct packed {
      logic                used;
      logic [OFS_BITS-1:0] size;
      logic [OFS_BITS-1:0] offset;
   } seg_type;

endpackage

[hw/rtl/fpsa_if.sv]
interface fpsa_req_if import fpsa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_BITS-1:0] func;
   logic [OFS_BITS-1:0]  amount;
   logic [OFS_BITS-1:0]  address;
   modport source  (output valid, func, amount, address, input ready);
   modport sink    (input valid, func, amount, address, output ready);
   modport monitor (input valid, func, amount, address, ready);
endinterface

interface fpsa_rsp_if import fpsa_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OFS_BITS-1:0]    payload_offset;
   logic [STATUS_BITS-1:0] status;
   logic [FRAG_BITS-1:0]   fragment_count;
   modport source  (output valid, payload_offset, status, fragment_count, input ready);
   modport sink    (input valid, payload_offset, status, fragment_count, output ready);
   modport monitor (input valid, payload_offset, status, fragment_count, ready);
endinterface

interface fpsa_csr_if import fpsa_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [REG_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source  (output valid, index, data, input ready);
   modport sink    (input valid, index, data, output ready);
   modport monitor (input valid, index, data, ready);
endinterface

[hw/rtl/fit_policy_segment_allocator.sv]
// Segment allocator over an address-ordered table of heap segments.
//
// req_bus carries func (allocate, free, count), amount and address; rsp_bus
// returns payload_offset, status and fragment_count, one response per request.
// csr_bus writes heap_size (index 0, also restarts the table as one free
// segment), header_bytes (1) and policy (2); it is always ready and must only
// be used while no request is in flight.
//
// Requests are worked one at a time by a sequencer walking the table through
// a single read and a single write port, one entry per cycle. Count scans the
// table; free finds the address, then merges free runs in a second pass;
// allocate scans for a fit, shifts the entries behind it up and splits it.
// req_bus.ready is high only while the sequencer is idle.
// The response sits in an output register; a stalled receiver holds it there,
// and a following request may run but waits to finish until it is taken.
// Reset (synchronous) restores a 65536-byte heap with 24-byte headers, best
// fit, and a single free segment; no clearing pass is needed.
module fit_policy_segment_allocator import fpsa_pkg::*; #(
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic       clock,
   input  logic       reset,
   fpsa_req_if.sink   req_bus,
   fpsa_rsp_if.source rsp_bus,
   fpsa_csr_if.sink   csr_bus
);

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_DECIDE = 4'd2;
   localparam logic [3:0] S_SHIFT  = 4'd3;
   localparam logic [3:0] S_WPICK  = 4'd4;
   localparam logic [3:0] S_WNEXT  = 4'd5;
   localparam logic [3:0] S_MERGE  = 4'd6;
   localparam logic [3:0] S_MFLUSH = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0]             state_ff, state_in;
   logic [OFS_BITS-1:0]    heap_ff, heap_in;
   logic [HDR_BITS-1:0]    hdr_ff, hdr_in;
   logic                   policy_ff, policy_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [CW-1:0]          i_ff, i_in;
   logic [CW-1:0]          j_ff, j_in;
   logic [CW-1:0]          w_ff, w_in;
   logic [IW-1:0]          pick_ff, pick_in;
   logic                   found_ff, found_in;
   logic [OFS_BITS-1:0]    pick_size_ff, pick_size_in;
   logic [OFS_BITS-1:0]    pick_off_ff, pick_off_in;
   logic [FUNC_BITS-1:0]   func_ff, func_in;
   logic [OFS_BITS-1:0]    amount_ff, amount_in;
   logic [OFS_BITS-1:0]    address_ff, address_in;
   logic [OFS_BITS+1:0]    need_ff, need_in;
   logic [OFS_BITS+1:0]    piece_ff, piece_in;
   seg_type                held_ff, held_in;
   logic [OFS_BITS-1:0]    res_pay_ff, res_pay_in;
   logic [STATUS_BITS-1:0] res_st_ff, res_st_in;
   logic [FRAG_BITS-1:0]   res_frag_ff, res_frag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OFS_BITS-1:0]    rsp_pay_ff, rsp_pay_in;
   logic [STATUS_BITS-1:0] rsp_st_ff, rsp_st_in;
   logic [FRAG_BITS-1:0]   rsp_frag_ff, rsp_frag_in;

   logic                   req_xfer;
   logic                   csr_xfer;
   logic                   tbl_init;
   logic                   wr_en;
   logic [IW-1:0]          wr_idx;
   seg_type                wr_data;
   logic [IW-1:0]          rd_idx;
   seg_type                rd_data;
   seg_type                cur;
   logic                   last;
   logic [OFS_BITS+1:0]    rounded;
   logic [OFS_BITS:0]      off_hdr;
   logic [OFS_BITS+1:0]    thresh;
   logic [OFS_BITS-1:0]    new_size;
   logic [OFS_BITS:0]      next_off;
   logic [OFS_BITS:0]      merged;
   logic [OFS_BITS:0]      pay_sum;

   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_xfer      = csr_bus.valid && csr_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign tbl_init      = csr_xfer && (csr_bus.index == REG_HEAP_SIZE);

   fpsa_table #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_table (
      .clock     (clock),
      .reset     (reset),
      .init      (tbl_init),
      .init_size (csr_bus.data),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data),
      .rd_idx    (rd_idx),
      .rd_data   (rd_data)
   );

   assign last     = (i_ff == cnt_ff - 1'b1);
   assign rounded  = ({2'b0, req_bus.amount} + 23'd3) & ~23'd3;
   assign off_hdr  = {1'b0, rd_data.offset} + (OFS_BITS+1)'(hdr_ff);
   assign thresh   = {2'b0, amount_ff} + (OFS_BITS+2)'(hdr_ff);
   assign new_size = pick_size_ff - piece_ff[OFS_BITS-1:0];
   assign next_off = {1'b0, pick_off_ff} + {1'b0, new_size};
   assign merged   = {1'b0, held_ff.size} + {1'b0, cur.size};
   assign pay_sum  = {1'b0, next_off[OFS_BITS-1:0]} + (OFS_BITS+1)'(hdr_ff);

   // current entry as seen by the merge pass, with the freed segment cleared
   always_comb begin
      cur = rd_data;
      if (found_ff && (i_ff[IW-1:0] == pick_ff)) begin
         cur.used = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      heap_in      = heap_ff;
      hdr_in       = hdr_ff;
      policy_in    = policy_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      w_in         = w_ff;
      pick_in      = pick_ff;
      found_in     = found_ff;
      pick_size_in = pick_size_ff;
      pick_off_in  = pick_off_ff;
      func_in      = func_ff;
      amount_in    = amount_ff;
      address_in   = address_ff;
      need_in      = need_ff;
      piece_in     = piece_ff;
      held_in      = held_ff;
      res_pay_in   = res_pay_ff;
      res_st_in    = res_st_ff;
      res_frag_in  = res_frag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_frag_in  = rsp_frag_ff;
      wr_en        = 1'b0;
      wr_idx       = w_ff[IW-1:0];
      wr_data      = held_ff;
      rd_idx       = i_ff[IW-1:0];

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_xfer) begin
         case (csr_bus.index)
            REG_HEAP_SIZE: begin
               heap_in = csr_bus.data;
               cnt_in  = CW'(1);
            end
            REG_HEADER: hdr_in    = csr_bus.data[HDR_BITS-1:0];
            REG_POLICY: policy_in = csr_bus.data[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               func_in     = req_bus.func;
               amount_in   = req_bus.amount;
               address_in  = req_bus.address;
               need_in     = rounded + {(OFS_BITS-HDR_BITS+1)'(0), hdr_ff, 1'b0};
               piece_in    = rounded + (OFS_BITS+2)'(hdr_ff);
               i_in        = '0;
               found_in    = 1'b0;
               pick_in     = '0;
               res_pay_in  = '0;
               res_st_in   = ST_OK;
               res_frag_in = '0;
               state_in    = S_SCAN;
               if (req_bus.func == FUNC_ALLOC) begin
                  if ((req_bus.amount == '0) ||
                      ({1'b0, heap_ff} < (OFS_BITS+1)'(hdr_ff) + 22'd4)) begin
                     res_st_in = ST_BADSIZE;
                     state_in  = S_DONE;
                  end
               end else if ((req_bus.func != FUNC_FREE) && (req_bus.func != FUNC_COUNT)) begin
                  state_in = S_DONE;
               end
            end
         end

         S_SCAN: begin
            case (func_ff)
               FUNC_ALLOC: begin
                  if (!rd_data.used) begin
                     if (policy_ff) begin
                        if (!found_ff || (rd_data.size > pick_size_ff)) begin
                           found_in     = 1'b1;
                           pick_in      = i_ff[IW-1:0];
                           pick_size_in = rd_data.size;
                           pick_off_in  = rd_data.offset;
                        end
                     end else if ({2'b0, rd_data.size} >= need_ff) begin
                        if (!found_ff || (rd_data.size < pick_size_ff)) begin
                           found_in     = 1'b1;
                           pick_in      = i_ff[IW-1:0];
                           pick_size_in = rd_data.size;
                           pick_off_in  = rd_data.offset;
                        end
                     end
                  end
               end
               FUNC_FREE: begin
                  if (!found_ff && (off_hdr == {1'b0, address_ff})) begin
                     found_in = 1'b1;
                     pick_in  = i_ff[IW-1:0];
                  end
               end
               default: begin
                  if (!rd_data.used && ({2'b0, rd_data.size} < thresh)) begin
                     res_frag_in = res_frag_ff + 1'b1;
                  end
               end
            endcase
            i_in = i_ff + 1'b1;
            if (last) begin
               case (func_ff)
                  FUNC_ALLOC: state_in = S_DECIDE;
                  FUNC_FREE: begin
                     i_in     = '0;
                     w_in     = '0;
                     state_in = S_MERGE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_DECIDE: begin
            j_in = cnt_ff;
            if (!found_ff || ({2'b0, pick_size_ff} < need_ff)) begin
               res_st_in = ST_NOFIT;
               state_in  = S_DONE;
            end else if (cnt_ff >= CW'(MAX_SEGMENTS)) begin
               res_st_in = ST_FULL;
               state_in  = S_DONE;
            end else if (cnt_ff >= CW'(pick_ff) + CW'(2)) begin
               state_in = S_SHIFT;
            end else begin
               state_in = S_WPICK;
            end
         end

         S_SHIFT: begin
            // move entry j-1 up to j, walking down towards the split point
            rd_idx  = IW'(j_ff - 1'b1);
            wr_en   = 1'b1;
            wr_idx  = j_ff[IW-1:0];
            wr_data = rd_data;
            j_in    = j_ff - 1'b1;
            if (j_ff == CW'(pick_ff) + CW'(2)) begin
               state_in = S_WPICK;
            end
         end

         S_WPICK: begin
            wr_en    = 1'b1;
            wr_idx   = pick_ff;
            wr_data  = '{used: 1'b0, size: new_size, offset: pick_off_ff};
            state_in = S_WNEXT;
         end

         S_WNEXT: begin
            wr_en      = 1'b1;
            wr_idx     = pick_ff + 1'b1;
            wr_data    = '{used: 1'b1, size: piece_ff[OFS_BITS-1:0],
                           offset: next_off[OFS_BITS-1:0]};
            cnt_in     = cnt_ff + 1'b1;
            res_pay_in = pay_sum[OFS_BITS-1:0];
            state_in   = S_DONE;
         end

         S_MERGE: begin
            // compact the table, folding each free run into its first entry
            if (i_ff == '0) begin
               held_in = cur;
            end else if (!held_ff.used && !cur.used) begin
               held_in.size = merged[OFS_BITS-1:0];
            end else begin
               wr_en   = 1'b1;
               w_in    = w_ff + 1'b1;
               held_in = cur;
            end
            i_in = i_ff + 1'b1;
            if (last) begin
               state_in = S_MFLUSH;
            end
         end

         S_MFLUSH: begin
            wr_en     = 1'b1;
            cnt_in    = w_ff + 1'b1;
            res_st_in = found_ff ? ST_OK : ST_NOTFOUND;
            state_in  = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pay_in   = res_pay_ff;
               rsp_st_in    = res_st_ff;
               rsp_frag_in  = res_frag_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         heap_ff      <= HEAP_SIZE_RST;
         hdr_ff       <= HEADER_RST;
         policy_ff    <= 1'b0;
         cnt_ff       <= CW'(1);
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heap_ff      <= heap_in;
         hdr_ff       <= hdr_in;
         policy_ff    <= policy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      w_ff         <= w_in;
      pick_ff      <= pick_in;
      pick_size_ff <= pick_size_in;
      pick_off_ff  <= pick_off_in;
      func_ff      <= func_in;
      amount_ff    <= amount_in;
      address_ff   <= address_in;
      need_ff      <= need_in;
      piece_ff     <= piece_in;
      held_ff      <= held_in;
      res_pay_ff   <= res_pay_in;
      res_st_ff    <= res_st_in;
      res_frag_ff  <= res_frag_in;
      rsp_pay_ff   <= rsp_pay_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_frag_ff  <= rsp_frag_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.payload_offset = rsp_pay_ff;
   assign rsp_bus.status         = rsp_st_ff;
   assign rsp_bus.fragment_count = rsp_frag_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) && (cnt_ff <= CW'(MAX_SEGMENTS)))
      else $error("segment count out of range");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_bus.ready)
      else $error("accepted a request while busy");

   a_pay_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_pay_ff != '0)) |-> (rsp_st_ff == ST_OK) && (rsp_frag_ff == '0))
      else $error("payload offset on failed or non-allocate response");

   a_frag_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_frag_ff != '0)) |-> (rsp_st_ff == ST_OK))
      else $error("fragment count with non-ok status");

endmodule

[hw/rtl/fpsa_table.sv]
module fpsa_table import fpsa_pkg::*; #(
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            init,
   input  logic [OFS_BITS-1:0]             init_size,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_SEGMENTS)-1:0] wr_idx,
   input  seg_type                         wr_data,
   input  logic [$clog2(MAX_SEGMENTS)-1:0] rd_idx,
   output seg_type                         rd_data
);

   seg_type seg_ff [MAX_SEGMENTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff[0] <= '{used: 1'b0, size: HEAP_SIZE_RST, offset: '0};
      end else if (init) begin
         seg_ff[0] <= '{used: 1'b0, size: init_size, offset: '0};
      end else if (wr_en) begin
         seg_ff[wr_idx] <= wr_data;
      end
   end

   assign rd_data = seg_ff[rd_idx];

endmodule

[test/fpsa_alloc_checker.sv]
module fpsa_alloc_checker import fpsa_pkg::*; #(
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic        clock,
   input  logic        reset,
   fpsa_req_if.monitor req_mon,
   fpsa_rsp_if.monitor rsp_mon,
   fpsa_csr_if.monitor csr_mon,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [OFS_BITS-1:0]    payload_offset;
      logic [STATUS_BITS-1:0] status;
      logic [FRAG_BITS-1:0]   fragment_count;
   } answer_type;

   logic [OFS_BITS-1:0] heap_bytes;
   logic [HDR_BITS-1:0] hdr_bytes;
   logic                worst_fit;
   longint              seg_ofs  [MAX_SEGMENTS];
   longint              seg_len  [MAX_SEGMENTS];
   bit                  seg_busy [MAX_SEGMENTS];
   int                  live;
   answer_type          answers_due[$];

   function automatic void clear_table();
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
         seg_ofs[i] = 0; seg_len[i] = 0; seg_busy[i] = 0;
      end
      seg_len[0] = heap_bytes;
      live = 1;
   endfunction

   function automatic void drop_entry(int idx);
      for (int i = idx; i + 1 < live; i++) begin
         seg_ofs[i] = seg_ofs[i+1]; seg_len[i] = seg_len[i+1]; seg_busy[i] = seg_busy[i+1];
      end
      live--;
   endfunction

   function automatic answer_type allocator_answer(logic [FUNC_BITS-1:0] func,
                                                   longint amount, longint address);
      answer_type a;
      longint     rounded, need, piece;
      int         pick;
      bit         found;
      a = '0;
      pick = 0;
      found = 0;
      a.status = ST_OK;
      if (func == FUNC_ALLOC) begin
         if (amount == 0 || heap_bytes < hdr_bytes + 4) begin
            a.status = ST_BADSIZE;
            return a;
         end
         rounded = (amount + 3) & ~64'd3;
         need = rounded + 2 * hdr_bytes;
         for (int i = 0; i < live; i++) begin
            if (seg_busy[i]) continue;
            if (worst_fit) begin
               if (!found || seg_len[i] > seg_len[pick]) begin
                  pick = i; found = 1;
               end
            end else if (seg_len[i] >= need) begin
               if (!found || seg_len[i] < seg_len[pick]) begin
                  pick = i; found = 1;
               end
            end
         end
         if (!found || seg_len[pick] < need) a.status = ST_NOFIT;
         else if (live >= MAX_SEGMENTS) a.status = ST_FULL;
         else begin
            piece = hdr_bytes + rounded;
            for (int j = live; j > pick + 1; j--) begin
               seg_ofs[j] = seg_ofs[j-1]; seg_len[j] = seg_len[j-1];
               seg_busy[j] = seg_busy[j-1];
            end
            seg_len[pick] = seg_len[pick] - piece;
            seg_ofs[pick+1] = (seg_ofs[pick] + seg_len[pick]) & 64'h1FFFFF;
            seg_len[pick+1] = piece & 64'h1FFFFF;
            seg_busy[pick+1] = 1;
            live++;
            a.payload_offset = OFS_BITS'(seg_ofs[pick+1] + hdr_bytes);
         end
      end else if (func == FUNC_FREE) begin
         a.status = ST_NOTFOUND;
         for (int i = 0; i < live; i++) begin
            if (seg_ofs[i] + hdr_bytes == address) begin
               seg_busy[i] = 0; a.status = ST_OK;
               break;
            end
         end
         for (int i = 0; i + 1 < live; ) begin
            if (!seg_busy[i] && !seg_busy[i+1]) begin
               seg_len[i] = (seg_len[i] + seg_len[i+1]) & 64'h1FFFFF;
               drop_entry(i + 1);
            end else i++;
         end
      end else if (func == FUNC_COUNT) begin
         // payload may go negative when a segment is smaller than its header
         for (int i = 0; i < live; i++)
            if (!seg_busy[i] && seg_len[i] - longint'(hdr_bytes) < amount)
               a.fragment_count = a.fragment_count + 1'b1;
      end
      return a;
   endfunction

   assign pending = answers_due.size();

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         heap_bytes = HEAP_SIZE_RST;
         hdr_bytes  = HEADER_RST;
         worst_fit  = 1'b0;
         clear_table();
         answers_due.delete();
         fail_count <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_HEAP_SIZE: begin
                  heap_bytes = csr_mon.data;
                  clear_table();
               end
               REG_HEADER: hdr_bytes = csr_mon.data[HDR_BITS-1:0];
               REG_POLICY: worst_fit = csr_mon.data[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            answers_due.push_back(allocator_answer(req_mon.func, req_mon.amount,
                                                    req_mon.address));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (answers_due.size() == 0) begin
               if (fail_count < 10) $display("unexpected response transfer");
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (want != {rsp_mon.payload_offset, rsp_mon.status, rsp_mon.fragment_count})
               begin
                  if (fail_count < 10)
                     $display({"mismatch: exp ofs %0d st %0d frag %0d, ",
                               "got ofs %0d st %0d frag %0d"},
                              want.payload_offset, want.status, want.fragment_count,
                              rsp_mon.payload_offset, rsp_mon.status, rsp_mon.fragment_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

[test/tb_fit_policy_segment_allocator.sv]
module tb_fit_policy_segment_allocator import fpsa_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   bit   calm;
   bit   done;
   logic [OFS_BITS-1:0] handed_out[$];

   fpsa_req_if req_bus();
   fpsa_rsp_if rsp_bus();
   fpsa_csr_if csr_bus();

   fit_policy_segment_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   fpsa_alloc_checker u_checker (
      .clock(clock), .reset(reset),
      .req_mon(req_bus.monitor), .rsp_mon(rsp_bus.monitor), .csr_mon(csr_bus.monitor),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   // receiver stalls in bursts
   initial begin
      rsp_bus.ready = 0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_bus.ready <= 1;
      end
   end

   // collect offsets handed out so frees can target live segments
   always @(posedge clock)
      if (rsp_bus.valid && rsp_bus.ready && rsp_bus.status == ST_OK &&
          rsp_bus.payload_offset != 0)
         handed_out.push_back(rsp_bus.payload_offset);

   // valid stays high after a transfer; an idle stretch or a pause in the stimulus drops it
   task automatic send_item(logic [FUNC_BITS-1:0] func, int amount, int address);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid   <= 1;
      req_bus.func    <= func;
      req_bus.amount  <= OFS_BITS'(amount);
      req_bus.address <= OFS_BITS'(address);
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, int value);
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data  <= CSR_DATA_BITS'(value);
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 0;
      @(posedge clock);
      handed_out.delete();
   endtask

   task automatic random_item();
      int pick;
      int k;
      pick = $urandom_range(0, 19);
      if (pick < 9)
         send_item(FUNC_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2097151)
                   : $urandom_range(1, 3000), $urandom);
      else if (pick < 16 && handed_out.size() > 0) begin
         k = $urandom_range(0, handed_out.size() - 1);
         send_item(FUNC_FREE, $urandom, handed_out[k]);
         handed_out.delete(k);
      end else if (pick < 18)
         send_item(FUNC_COUNT, $urandom_range(0, 9) == 0 ? $urandom_range(0, 2097151)
                   : $urandom_range(0, 4000), $urandom);
      else
         send_item(FUNC_FREE, $urandom, $urandom_range(0, 2097151));
      if (pick == 19 && $urandom_range(0, 3) == 0) send_item(FUNC_UNUSED, $urandom, $urandom);
   endtask

   initial begin
      reset = 1;
      calm = 0;
      req_bus.valid = 0; req_bus.func = FUNC_ALLOC; req_bus.amount = 0; req_bus.address = 0;
      csr_bus.valid = 0; csr_bus.index = REG_HEAP_SIZE; csr_bus.data = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      send_item(FUNC_ALLOC, 0, 0);
      send_item(FUNC_ALLOC, 1, 0);
      send_item(FUNC_ALLOC, 5, 0);
      send_item(FUNC_ALLOC, 2097151, 0);
      send_item(FUNC_ALLOC, 65536 - 48, 0);
      send_item(FUNC_COUNT, 0, 0);
      send_item(FUNC_COUNT, 2097151, 0);
      send_item(FUNC_FREE, 0, 2097151);
      send_item(FUNC_FREE, 0, 24);
      send_item(FUNC_FREE, 0, 24);
      send_item(FUNC_UNUSED, 2097151, 2097151);
      for (int i = 0; i < 34; i++) send_item(FUNC_ALLOC, 4, 0);
      send_item(FUNC_COUNT, 100, 0);
      drain();
      write_reg(REG_HEADER, 1);
      write_reg(REG_HEAP_SIZE, 4);
      send_item(FUNC_ALLOC, 1, 0);
      drain();
      write_reg(REG_HEAP_SIZE, 0);
      send_item(FUNC_ALLOC, 3, 0);
      send_item(FUNC_COUNT, 1, 0);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         write_reg(REG_POLICY, phase % 2);
         write_reg(REG_HEADER, phase == 2 ? 64 : phase == 3 ? 1 : $urandom_range(1, 64));
         write_reg(REG_HEAP_SIZE, phase == 4 ? 1048576 : phase == 5 ? 2097151
                   : $urandom_range(200, 40000));
         if (phase == 7) calm = 1;
         for (int n = 0; n < 200; n++) begin
            random_item();
            if (n == 100) begin
               req_bus.valid <= 0;
               while (pending != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

[sim.f]
hw/rtl/fpsa_pkg.sv
hw/rtl/fpsa_if.sv
hw/rtl/fpsa_table.sv
hw/rtl/fit_policy_segment_allocator.sv
test/fpsa_alloc_checker.sv
test/tb_fit_policy_segment_allocator.sv
